FILE: hdl/fcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrc_pkg
// Shared types and constants for the recent-flow classifier cache.
// ----------------------------------------------------------------------------
package fcrc_pkg;

  // IP protocol numbers and TCP flag bits
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] FLAG_SYN  = 8'h02;
  localparam logic [7:0] FLAG_ACK  = 8'h10;

  // Configuration register reset values
  localparam logic [15:0] DNS_PORT_RST   = 16'd53;
  localparam logic [15:0] WATCH_PORT_RST = 16'd443;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DNS_PORT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_PORT = 8'd1;

  // Hit reduction: cell match bits are ORed in groups of this size
  localparam int unsigned GROUP_SIZE = 8;

  typedef enum logic [2:0] {
    V_IGNORED = 3'd0,
    V_DNS     = 3'd1,
    V_NEW     = 3'd2,
    V_SEEN    = 3'd3,
    V_SYNACK  = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_DONE
  } state_e;

  // One flow cache entry, also used as the lookup key
  typedef struct packed {
    logic        family;
    logic [31:0] ports;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } entry_t;

endpackage

FILE: hdl/fcrc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrc_cell
// One slot of the flow cache shift chain: holds an entry, takes its
// neighbor's entry on insert and registers whether it matches the key.
// ----------------------------------------------------------------------------
module fcrc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  fcrc_pkg::entry_t prev_i,
  input  fcrc_pkg::entry_t key_i,
  input  logic            valid_i,
  output fcrc_pkg::entry_t entry_o,
  output logic            match_o
);
  import fcrc_pkg::*;

  entry_t entry_q;
  logic   match_q;
  logic   match_d;

  // entry register, loads the neighbor's entry on insert
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= prev_i;
    end
  end

  // compare: IPv4 entries check only the low 32 address bits
  always_comb begin
    match_d = valid_i
           && (entry_q.family == key_i.family)
           && (entry_q.ports == key_i.ports)
           && (entry_q.addr_lo[31:0] == key_i.addr_lo[31:0]);
    if (key_i.family) begin
      match_d = match_d
             && (entry_q.addr_lo[63:32] == key_i.addr_lo[63:32])
             && (entry_q.addr_hi == key_i.addr_hi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

FILE: hdl/fcrc_hit_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrc_hit_tree
// Registered OR reduction of the cell match bits: groups first, then the
// final OR over the registered group bits.
// ----------------------------------------------------------------------------
module fcrc_hit_tree #(
  parameter int unsigned N = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [N-1:0] match_i,
  output logic         hit_o
);
  import fcrc_pkg::*;

  localparam int unsigned NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [NG*GROUP_SIZE-1:0] padded;
  logic [NG-1:0]            group_d;
  logic [NG-1:0]            group_q;

  // zero pad to whole groups
  always_comb begin
    padded = '0;
    padded[N-1:0] = match_i;
    for (int g = 0; g < NG; g++) begin
      group_d[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
    end else begin
      group_q <= group_d;
    end
  end

  assign hit_o = |group_q;

endmodule

FILE: hdl/flow_classifier_recent_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_classifier_recent_cache
// Classifies parsed packet headers and tracks recent watched UDP flows in a
// FIFO cache built as a shift chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one header item; the
//   output channel (out_valid_o / out_stall_i) returns one verdict item and
//   the cache fill count per input item, in order.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) set the DNS port
//   (index 0) and the watched port (index 1); other indexes are dropped.
//   Steps: a watched-port item passes the key register, per-cell compare,
//   group OR and decide/insert before the next accept; every other item
//   goes from the key register straight to the decide step. The result is
//   registered and shown the cycle after the decide step.
//   New flows enter at cell 0 and push older ones down the chain; when
//   all CACHE_DEPTH cells hold flows the last (oldest) one drops out.
//   A waiting result does not block the next accept; a decided result
//   waits in the decide step while the output register is still full.
//   Reset empties the cache (fill count zero, no clearing pass) and loads
//   the port registers with 53 and 443.
// ----------------------------------------------------------------------------
module flow_classifier_recent_cache #(
  parameter int unsigned CACHE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [fcrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           is_ipv6_i,
  input  logic [7:0]                     proto_i,
  input  logic [15:0]                    src_port_i,
  input  logic [15:0]                    dst_port_i,
  input  logic [7:0]                     tcp_flags_i,
  input  logic [63:0]                    dst_addr_hi_i,
  input  logic [63:0]                    dst_addr_lo_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     verdict_o,
  output logic [6:0]                     cache_fill_o
);
  import fcrc_pkg::*;

  localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(CACHE_DEPTH);

  state_e          state_q, state_d;
  logic [15:0]     dns_port_q;
  logic [15:0]     watch_port_q;
  entry_t          key_q;
  verdict_e        cls_q, cls_d;
  logic            watched_q, watched_d;
  logic [CW-1:0]   count_q, count_d;
  logic            out_valid_q;
  verdict_e        out_verdict_q;
  logic [6:0]      out_fill_q;

  logic            in_acc;
  logic            out_free;
  logic            load_out;
  logic            insert;
  logic            hit;
  verdict_e        verdict_d;
  entry_t          key_d;
  entry_t          chain [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] match;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q   <= DNS_PORT_RST;
      watch_port_q <= WATCH_PORT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DNS_PORT:   dns_port_q   <= cfg_data_i;
        CFG_WATCH_PORT: watch_port_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classify at accept; DNS takes priority over the watched port
  always_comb begin
    cls_d     = V_IGNORED;
    watched_d = 1'b0;
    if (proto_i == PROTO_UDP) begin
      if (src_port_i == dns_port_q || dst_port_i == dns_port_q) begin
        cls_d = V_DNS;
      end else if (dst_port_i == watch_port_q) begin
        cls_d     = V_NEW;
        watched_d = 1'b1;
      end
    end else if (proto_i == PROTO_TCP) begin
      if ((tcp_flags_i & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK)) begin
        cls_d = V_SYNACK;
      end
    end
    key_d.family  = is_ipv6_i;
    key_d.ports   = {src_port_i, dst_port_i};
    key_d.addr_hi = dst_addr_hi_i;
    key_d.addr_lo = dst_addr_lo_i;
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q     <= key_d;
      cls_q     <= cls_d;
      watched_q <= watched_d;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    load_out  = 1'b0;
    insert    = 1'b0;
    verdict_d = cls_q;
    count_d   = count_q;
    if (watched_q) begin
      verdict_d = hit ? V_SEEN : V_NEW;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = watched_d ? S_MATCH : S_DONE;
        end
      end
      S_MATCH: state_d = S_GROUP;
      S_GROUP: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          insert   = watched_q && !hit;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (insert && count_q != DEPTH_C) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // cell chain: cell 0 holds the newest flow
  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    entry_t prev;
    logic   valid;
    if (i == 0) begin : g_head
      assign prev = key_q;
    end else begin : g_link
      assign prev = chain[i-1];
    end
    assign valid = (CW'(i) < count_q);
    fcrc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (insert),
      .prev_i  (prev),
      .key_i   (key_q),
      .valid_i (valid),
      .entry_o (chain[i]),
      .match_o (match[i])
    );
  end

  fcrc_hit_tree #(
    .N (CACHE_DEPTH)
  ) u_hit_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .match_i (match),
    .hit_o   (hit)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_verdict_q <= verdict_d;
      out_fill_q    <= 7'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = out_verdict_q;
  assign cache_fill_o = out_fill_q;

`ifndef SYNTHESIS
  // fill count never passes the cache depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("cache fill count above depth");

  // fill count only grows by one, and only on a result load
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CW'(1)) && $past(load_out)))
    else $error("cache fill count changed unexpectedly");

  // an accepted item closes the input until its result is decided
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input open right after accept");

  // a seen verdict never comes with an insert
  a_seen_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && verdict_d == V_SEEN) |-> !insert)
    else $error("insert on a cache hit");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the recent-flow classifier cache. A short table of
// directed headers runs first. Randomized phases follow under several DNS and
// watched-port settings. Every verdict and fill count is checked in order,
// typed rows against the table, others against a behavioral FIFO cache copy.
// ----------------------------------------------------------------------------
module tb;
  import fcrc_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned POOL_MAX    = 128;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_WATCH_PORT + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = '1;

  localparam logic [63:0] ADDR_V4 = 64'h0000_0000_C0A8_0001;
  localparam logic [63:0] ONES    = '1;

  typedef struct packed {
    logic        is_ipv6;
    logic [7:0]  proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
  } hdr_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [6:0]  fill;
  } result_t;

  typedef struct {
    hdr_t    hdr;
    bit      typed;
    result_t res;
  } dir_row_t;

  // DUT-facing signals
  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [15:0]          cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 is_ipv6   = 1'b0;
  logic [7:0]           proto     = '0;
  logic [15:0]          src_port  = '0;
  logic [15:0]          dst_port  = '0;
  logic [7:0]           tcp_flags = '0;
  logic [63:0]          addr_hi   = '0;
  logic [63:0]          addr_lo   = '0;
  logic                 out_valid;
  logic                 rx_stall  = 1'b0;
  logic [2:0]           verdict;
  logic [6:0]           cache_fill;

  // flow cache predictor state
  logic [15:0] dns_port_p   = DNS_PORT_RST;
  logic [15:0] watch_port_p = WATCH_PORT_RST;
  entry_t      flow_cache [DEPTH];
  int unsigned cache_head   = 0;
  int unsigned cache_count  = 0;

  result_t     expected_results [$];
  dir_row_t    dir_tab [$];

  int unsigned n_sent = 0, n_checked = 0, n_errors = 0, n_settings = 1;
  int unsigned n_new = 0, n_hit = 0, n_evict = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  flow_classifier_recent_cache #(
    .CACHE_DEPTH (DEPTH)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .is_ipv6_i     (is_ipv6),
    .proto_i       (proto),
    .src_port_i    (src_port),
    .dst_port_i    (dst_port),
    .tcp_flags_i   (tcp_flags),
    .dst_addr_hi_i (addr_hi),
    .dst_addr_lo_i (addr_lo),
    .out_valid_o   (out_valid),
    .out_stall_i   (rx_stall),
    .verdict_o     (verdict),
    .cache_fill_o  (cache_fill)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Classify one header and update the predicted cache on a watched miss
  function automatic result_t classify_header(input hdr_t h);
    result_t     r;
    entry_t      key;
    int unsigned k;
    int unsigned slot;
    bit          hit;
    r.verdict = V_IGNORED;
    if (h.proto == PROTO_UDP) begin
      if (h.src_port == dns_port_p || h.dst_port == dns_port_p) begin
        r.verdict = V_DNS;
      end else if (h.dst_port == watch_port_p) begin
        key.family  = h.is_ipv6;
        key.ports   = {h.src_port, h.dst_port};
        key.addr_hi = h.dst_addr_hi;
        key.addr_lo = h.dst_addr_lo;
        hit = 1'b0;
        for (k = 0; k < cache_count; k++) begin
          slot = (cache_head + k) % DEPTH;
          // IPv4 flows compare only the low 32 address bits
          if (flow_cache[slot].family == key.family && flow_cache[slot].ports == key.ports &&
              (key.family ? (flow_cache[slot].addr_hi == key.addr_hi &&
                             flow_cache[slot].addr_lo == key.addr_lo)
                          : (flow_cache[slot].addr_lo[31:0] == key.addr_lo[31:0])))
            hit = 1'b1;
        end
        if (hit) begin
          r.verdict = V_SEEN;
          n_hit++;
        end else begin
          // full cache: overwrite the oldest flow
          if (cache_count >= DEPTH) begin
            slot = cache_head;
            cache_head = (cache_head + 1) % DEPTH;
            n_evict++;
          end else begin
            slot = (cache_head + cache_count) % DEPTH;
            cache_count++;
          end
          flow_cache[slot] = key;
          r.verdict = V_NEW;
          n_new++;
        end
      end
    end else if (h.proto == PROTO_TCP) begin
      if ((h.tcp_flags & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK))
        r.verdict = V_SYNACK;
    end
    r.fill = 7'(cache_count);
    return r;
  endfunction

  task automatic add_row(input logic v6, input logic [7:0] pr, input logic [15:0] sp,
                         input logic [15:0] dp, input logic [7:0] fl, input logic [63:0] hi,
                         input logic [63:0] lo, input bit typed, input verdict_e v,
                         input logic [6:0] fill);
    dir_row_t row;
    row.hdr.is_ipv6     = v6;
    row.hdr.proto       = pr;
    row.hdr.src_port    = sp;
    row.hdr.dst_port    = dp;
    row.hdr.tcp_flags   = fl;
    row.hdr.dst_addr_hi = hi;
    row.hdr.dst_addr_lo = lo;
    row.typed           = typed;
    row.res.verdict     = v;
    row.res.fill        = fill;
    dir_tab.push_back(row);
  endtask

  // Present one header item, hold it until accepted, then record its result
  task automatic offer_header(input hdr_t h, input bit typed, input result_t typed_res);
    result_t r;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    is_ipv6   <= h.is_ipv6;
    proto     <= h.proto;
    src_port  <= h.src_port;
    dst_port  <= h.dst_port;
    tcp_flags <= h.tcp_flags;
    addr_hi   <= h.dst_addr_hi;
    addr_lo   <= h.dst_addr_lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = classify_header(h);
    expected_results.push_back(typed ? typed_res : r);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_DNS_PORT:   dns_port_p   = data;
      CFG_WATCH_PORT: watch_port_p = data;
      default: ;
    endcase
  endtask

  // New port setting, only once the block has gone quiet
  task automatic set_ports(input logic [15:0] dns, input logic [15:0] watch,
                           input logic [CFG_IDX_W-1:0] spare_idx, input logic [15:0] spare);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_DNS_PORT, dns);
    write_reg(CFG_WATCH_PORT, watch);
    write_reg(spare_idx, spare);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Stimulus
  initial begin : stimulus
    hdr_t        h;
    result_t     none;
    entry_t      pool [POOL_MAX];
    int unsigned pool_n, pick, kind, ph, it, k;
    logic [15:0] r16;
    none = '0;

    // fresh cache, default ports: dns 53, watched 443
    add_row(1'b0, 8'h00, 16'd0, 16'd0, 8'h00, 64'd0, 64'd0, 1, V_IGNORED, 7'd0);
    add_row(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, ONES, ONES, 1, V_IGNORED, 7'd0);
    add_row(1'b0, PROTO_UDP, 16'd53, 16'd1000, 8'h00, 64'd0, ADDR_V4, 1, V_DNS, 7'd0);
    add_row(1'b1, PROTO_UDP, 16'd5000, 16'd53, 8'hFF, ONES, ONES, 1, V_DNS, 7'd0);
    // DNS wins over the watched port
    add_row(1'b0, PROTO_UDP, 16'd53, 16'd443, 8'h00, 64'd0, ADDR_V4, 1, V_DNS, 7'd0);
    add_row(1'b0, PROTO_UDP, 16'd40000, 16'd443, 8'h00, 64'd0, ADDR_V4, 1, V_NEW, 7'd1);
    add_row(1'b0, PROTO_UDP, 16'd40000, 16'd443, 8'h00, 64'd0, ADDR_V4, 1, V_SEEN, 7'd1);
    // IPv4 hit despite junk in the upper 96 address bits
    add_row(1'b0, PROTO_UDP, 16'd40000, 16'd443, 8'h00, 64'hDEAD_BEEF_0123_4567,
            64'hFFFF_FFFF_C0A8_0001, 1, V_SEEN, 7'd1);
    add_row(1'b1, PROTO_UDP, 16'd40000, 16'd443, 8'h00, 64'd0, ADDR_V4, 1, V_NEW, 7'd2);
    add_row(1'b1, PROTO_UDP, 16'd40000, 16'd443, 8'h00, 64'd0, ADDR_V4, 1, V_SEEN, 7'd2);
    // IPv6 compares all 128 bits
    add_row(1'b1, PROTO_UDP, 16'd40000, 16'd443, 8'h00, 64'd1, ADDR_V4, 1, V_NEW, 7'd3);
    add_row(1'b1, PROTO_UDP, 16'd40000, 16'd443, 8'h00, 64'd1, 64'h1_C0A8_0001, 1, V_NEW,
            7'd4);
    add_row(1'b0, PROTO_UDP, 16'd40001, 16'd443, 8'h00, 64'd0, ADDR_V4, 1, V_NEW, 7'd5);
    add_row(1'b0, PROTO_TCP, 16'd0, 16'd0, 8'h12, 64'd0, 64'd0, 1, V_SYNACK, 7'd5);
    add_row(1'b1, PROTO_TCP, 16'hFFFF, 16'hFFFF, 8'hFF, ONES, ONES, 1, V_SYNACK, 7'd5);
    // TCP without both SYN and ACK set
    add_row(1'b0, PROTO_TCP, 16'd1234, 16'd443, 8'h02, 64'd0, ADDR_V4, 1, V_IGNORED, 7'd5);
    add_row(1'b0, PROTO_TCP, 16'd1234, 16'd443, 8'h10, 64'd0, ADDR_V4, 1, V_IGNORED, 7'd5);
    add_row(1'b0, PROTO_TCP, 16'd1234, 16'd443, 8'hED, 64'd0, ADDR_V4, 1, V_IGNORED, 7'd5);
    // watched port on the source side only
    add_row(1'b0, PROTO_UDP, 16'd443, 16'd444, 8'h00, 64'd0, ADDR_V4, 1, V_IGNORED, 7'd5);
    add_row(1'b0, PROTO_UDP, 16'd1000, 16'hFFFF, 8'h00, 64'd0, ADDR_V4, 1, V_IGNORED, 7'd5);
    add_row(1'b1, PROTO_UDP, 16'hFFFF, 16'd443, 8'h00, ONES, ONES, 0, V_IGNORED, 7'd0);
    add_row(1'b0, PROTO_UDP, 16'd0, 16'd443, 8'h00, 64'd0, 64'd0, 0, V_IGNORED, 7'd0);
    add_row(1'b0, PROTO_UDP, 16'd40001, 16'd443, 8'h00, ONES, 64'hABCD_0000_C0A8_0001, 0,
            V_IGNORED, 7'd0);
    add_row(1'b0, 8'd1, 16'd53, 16'd443, 8'h12, 64'd0, ADDR_V4, 1, V_IGNORED, 7'd7);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_tab[i]) offer_header(dir_tab[i].hdr, dir_tab[i].typed, dir_tab[i].res);
    in_valid <= 1'b0;
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: set_ports(16'h0000, 16'hFFFF, CFG_IDX_TOP, 16'hFFFF);
        2: set_ports(16'hFFFF, 16'h0000, CFG_IDX_SPARE, 16'h0000);
        3: begin
          r16 = 16'($urandom);
          set_ports(r16, r16 + 16'($urandom_range(1, 65535)), CFG_IDX_SPARE, 16'($urandom));
        end
        4: begin
          // same port for both: watched traffic turns into DNS
          r16 = 16'($urandom);
          set_ports(r16, r16, CFG_IDX_TOP, 16'($urandom));
        end
        5: begin
          calm = 1'b1;
          set_ports(DNS_PORT_RST, WATCH_PORT_RST, CFG_IDX_TOP, 16'h5555);
        end
        default: ;
      endcase

      // pool of recurring flows; pools above the depth force evictions
      case (ph)
        0: pool_n = 24;
        1: pool_n = 100;
        2: pool_n = 64;
        3: pool_n = 40;
        4: pool_n = 12;
        default: pool_n = 80;
      endcase
      for (k = 0; k < pool_n; k++) begin
        pool[k].family  = 1'($urandom_range(0, 1));
        pool[k].ports   = {16'($urandom), watch_port_p};
        pool[k].addr_hi = pool[k].family ? {$urandom, $urandom} : 64'd0;
        pool[k].addr_lo = pool[k].family ? {$urandom, $urandom} : {32'd0, 32'($urandom)};
      end

      for (it = 0; it < PHASE_ITEMS; it++) begin
        if (ph == 1 && it == 60) hold_req = 1'b1;
        if (ph == 2 && it == 100) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        kind          = $urandom_range(0, 99);
        h.is_ipv6     = 1'($urandom_range(0, 1));
        h.proto       = 8'($urandom);
        h.src_port    = 16'($urandom);
        h.dst_port    = 16'($urandom);
        h.tcp_flags   = 8'($urandom);
        h.dst_addr_hi = {$urandom, $urandom};
        h.dst_addr_lo = {$urandom, $urandom};
        if (kind < 60) begin
          // recurring watched flow
          pick = $urandom_range(0, pool_n - 1);
          h.proto = PROTO_UDP;
          h.is_ipv6 = pool[pick].family;
          {h.src_port, h.dst_port} = pool[pick].ports;
          h.dst_addr_hi = pool[pick].addr_hi;
          h.dst_addr_lo = pool[pick].addr_lo;
          if (!pool[pick].family && $urandom_range(0, 3) == 0) begin
            h.dst_addr_hi = {$urandom, $urandom};
            h.dst_addr_lo[63:32] = $urandom;
          end
          if ($urandom_range(0, 19) == 0)
            h.dst_addr_lo = h.dst_addr_lo ^ (64'd1 << $urandom_range(0, 63));
        end else if (kind < 68) begin
          h.proto = PROTO_UDP;
          if ($urandom_range(0, 1) == 1) h.src_port = dns_port_p;
          else h.dst_port = dns_port_p;
        end else if (kind < 78) begin
          h.proto = PROTO_TCP;
          if ($urandom_range(0, 1) == 1) h.tcp_flags = h.tcp_flags | FLAG_SYN | FLAG_ACK;
        end else if (kind < 85) begin
          // one-off watched flow
          h.proto = PROTO_UDP;
          h.dst_port = watch_port_p;
        end else begin
          case ($urandom_range(0, 2))
            0: h.proto = PROTO_UDP;
            1: h.proto = PROTO_TCP;
            default: ;
          endcase
        end
        offer_header(h, 1'b0, none);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (2 * SETTLE) @(posedge clk);
    $display("Run: %0d headers, %0d results checked across %0d port settings",
             n_sent, n_checked, n_settings);
    $display("Flow cache: %0d new flows, %0d hits, %0d evictions", n_new, n_hit, n_evict);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, in-order compare
  initial begin : result_side
    result_t     want;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !rx_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no header pending: verdict %0d, cache_fill %0d",
                 verdict, cache_fill);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
            n_errors++;
          end
          if (cache_fill !== want.fill) begin
            $error("cache_fill: expected %0d, actual %0d", want.fill, cache_fill);
            n_errors++;
          end
          n_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rx_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        rx_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rx_stall <= 1'b1;
      end else begin
        rx_stall <= 1'b0;
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
